// ===== rtl/core/ray_nearest_edge_picker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ray nearest-edge picker checker
// Both macros expect signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef RAY_NEAREST_EDGE_PICKER_ASSERT_SVH
`define RAY_NEAREST_EDGE_PICKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RNEP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rnep check failed");

// Consequent must hold in the cycle after the antecedent
`define RNEP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rnep check failed");

`endif

// ===== rtl/core/rnep_pkg.sv =====
// ----------------------------------------------------------------------------
// rnep_pkg
// Shared constants, register indexes and Q16.16 saturating helpers for the
// ray nearest-edge picker.
// ----------------------------------------------------------------------------
package rnep_pkg;

    typedef logic signed [31:0] q_t;

    localparam q_t QONE = 32'sd65536;
    localparam q_t QMAX = 32'sh7fffffff;
    localparam q_t QMIN = 32'sh80000000;

    localparam int unsigned MAX_EDGES_DEF   = 65536;
    localparam int unsigned COORD_WIDTH_DEF = 32;

    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned RADIUS_W    = 31;
    localparam int unsigned EDGE_NUM_W  = 16;
    localparam int unsigned PARAM_W     = 31;
    localparam int unsigned OUT_DATA_W  = 48;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_ORIGIN_Z    = 3'd2,
        REG_DIRECTION_X = 3'd3,
        REG_DIRECTION_Y = 3'd4,
        REG_DIRECTION_Z = 3'd5,
        REG_PICK_RADIUS = 3'd6
    } cfg_index_t;

    // Clamp a wide signed value into the Q16.16 range
    function automatic q_t sat32(input logic signed [63:0] v);
        q_t r;
        if (v > 64'sh000000007fffffff) begin
            r = QMAX;
        end else if (v < -64'sh0000000080000000) begin
            r = QMIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        return sat32(64'(a) + 64'(b));
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        return sat32(64'(a) - 64'(b));
    endfunction

    // Finish a Q16.16 product: floor shift and clamp
    function automatic q_t qmul_fin(input logic signed [63:0] p);
        return sat32(p >>> 16);
    endfunction

    function automatic logic [31:0] mag32(input q_t v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Apply sign and clamp to an unsigned quotient magnitude
    function automatic q_t div_fin(input logic [47:0] q, input logic neg, input logic zero);
        q_t r;
        if (zero) begin
            r = '0;
        end else if (neg) begin
            r = (q > 48'h000080000000) ? QMIN : q_t'(q_t'(0) - q_t'(q[31:0]));
        end else begin
            r = (q > 48'h00007fffffff) ? QMAX : q_t'(q[31:0]);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/ray_nearest_edge_picker.sv =====
// ----------------------------------------------------------------------------
// ray_nearest_edge_picker
// Picks the edge nearest to a configured ray within a pick radius. Edges
// stream in one word at a time; the last edge of a query emits one result.
//
//   channel | dir | handshake        | payload
//   s_*     | in  | tvalid / tready  | tdata: six endpoint coords, tuser, tlast
//   m_*     | out | tvalid / tready  | tdata: edge number, ray param; tuser
//   cfg_*   | in  | cfg_we           | cfg_addr, cfg_wdata
//
// One edge word at a time: ready only when the sequencer is idle. A skipped
// edge is quickest, a point-like edge takes longer and a full edge longest;
// the first edge of a query also normalizes the direction. The differences
// come from the shared 48-step divider and the 32-step square-root unit,
// each used several times per edge.
// Reset is asynchronous, active low. A pending result stalls the sequencer
// only when the next result is ready before it has been taken.
// ----------------------------------------------------------------------------
module ray_nearest_edge_picker #(
    parameter int unsigned MAX_EDGES   = rnep_pkg::MAX_EDGES_DEF,
    parameter int unsigned COORD_WIDTH = rnep_pkg::COORD_WIDTH_DEF,
    localparam int unsigned IN_DATA_W  = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // start_x, start_y, start_z, end_x, end_y, end_z (lowest first)
    input  logic [IN_DATA_W-1:0]              s_tdata,
    // is_candidate
    input  logic                              s_tuser,
    // last_edge
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // edge_number, ray_param (lowest first)
    output logic [rnep_pkg::OUT_DATA_W-1:0]   m_tdata,
    // found
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [rnep_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rnep_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int unsigned CNT_W = $clog2(MAX_EDGES);

    typedef enum logic [5:0] {
        ST_IDLE, ST_D_LEN, ST_D_GOT, ST_D_DIV, ST_D_Q,
        ST_E_START, ST_E_SUB, ST_E_LEN2, ST_E_PT_T, ST_E_BD, ST_E_DD, ST_E_ED,
        ST_E_DEN, ST_E_TN1, ST_E_TN2, ST_E_UN, ST_E_TQ, ST_E_UQ, ST_E_PA,
        ST_E_PAT, ST_E_PB, ST_E_PBT, ST_E_PROJ, ST_E_PRU, ST_E_DONE, ST_E_FIN,
        ST_C_CHK, ST_C_M1, ST_C_A1, ST_C_A2, ST_C_LEN, ST_C_CMP,
        ST_DOT_M, ST_DOT_A, ST_DIV, ST_SQ
    } st_t;

    typedef enum logic [2:0] {
        VP_SS, VP_RS, VP_RW, VP_SW, VP_PR, VP_BR, VP_DD, VP_FF
    } vp_t;

    // sequencer
    st_t                 state_reg, ret_reg, cons_ret_reg;
    vp_t                 vp_reg;
    logic [1:0]          k_reg;
    logic                pt_mode_reg;

    // configuration
    rnep_pkg::q_t        org_reg [3];
    rnep_pkg::q_t        dir_reg [3];
    logic [rnep_pkg::RADIUS_W-1:0] radius_reg;

    // query state
    rnep_pkg::q_t        ux_reg [3];
    logic                dir_ready_reg;
    logic                have_best_reg;
    logic [31:0]         best_d_reg, best_t_reg;
    logic [CNT_W-1:0]    best_num_reg, cnt_edge_reg, num_reg;

    // edge work registers
    rnep_pkg::q_t        a_reg [3], b_reg [3];
    logic                cand_reg, last_reg;
    rnep_pkg::q_t        seg_reg [3], w0_reg [3], pa_reg [3], pb_reg [3], diff_reg [3];
    rnep_pkg::q_t        len2_reg, bd_reg, dd_reg, ed_reg, den_reg;
    rnep_pkg::q_t        tnum_reg, unum_reg, tmp_reg, ct_reg, cu_reg;
    logic                s_have_reg;
    logic [31:0]         s_t_reg, s_d_reg;

    // shared arithmetic
    logic signed [63:0]  prod_reg;
    logic [63:0]         acc_reg;
    logic [47:0]         dv_num_reg;
    logic [31:0]         dv_rem_reg, dv_div_reg;
    logic                dv_neg_reg, dv_zero_reg;
    logic [5:0]          cnt_reg;
    logic [63:0]         sq_x_reg;
    logic [32:0]         sq_rem_reg;
    logic [31:0]         sq_root_reg;

    // output register
    logic                m_tvalid_reg, m_tuser_reg;
    logic [rnep_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    rnep_pkg::q_t        coord_in [6];
    rnep_pkg::q_t        va, vb, mul_a, mul_b;
    logic signed [63:0]  mul_p;
    rnep_pkg::q_t        qm_prod, dot_val, div_q;
    logic                sq_mode;
    rnep_pkg::q_t        dv_n, dv_d;
    logic                dv_dir;
    logic [31:0]         dv_nmag, dv_dmag;
    logic [32:0]         dv_remt;
    logic                dv_ge;
    logic [34:0]         sq_remt, sq_trial;
    logic                sq_ge;
    logic [CNT_W:0]      cnt_inc;
    logic                ux_nz;
    logic                better;

    // Bring input coordinates into the 32-bit Q16.16 range
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            coord_in[i] = rnep_pkg::sat32(
                64'($signed(s_tdata[i*COORD_WIDTH +: COORD_WIDTH])));
        end
    end

    // Dot-product operand pairs
    always_comb
    begin
        case (vp_reg)
            VP_SS:   begin va = seg_reg[k_reg];  vb = seg_reg[k_reg]; end
            VP_RS:   begin va = ux_reg[k_reg];   vb = seg_reg[k_reg]; end
            VP_RW:   begin va = ux_reg[k_reg];   vb = w0_reg[k_reg];  end
            VP_SW:   begin va = seg_reg[k_reg];  vb = w0_reg[k_reg];  end
            VP_PR:   begin va = pa_reg[k_reg];   vb = ux_reg[k_reg];  end
            VP_BR:   begin va = pb_reg[k_reg];   vb = ux_reg[k_reg];  end
            VP_DD:   begin va = dir_reg[k_reg];  vb = dir_reg[k_reg]; end
            VP_FF:   begin va = diff_reg[k_reg]; vb = diff_reg[k_reg]; end
            default: begin va = '0;              vb = '0;             end
        endcase
    end

    assign sq_mode = (vp_reg == VP_DD) || (vp_reg == VP_FF);

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DOT_M: begin mul_a = va;              mul_b = vb;       end
            ST_E_ED:  begin mul_a = bd_reg;          mul_b = bd_reg;   end
            ST_E_DEN: begin mul_a = bd_reg;          mul_b = ed_reg;   end
            ST_E_TN1: begin mul_a = len2_reg;        mul_b = dd_reg;   end
            ST_E_TN2: begin mul_a = bd_reg;          mul_b = dd_reg;   end
            ST_C_M1:  begin mul_a = ux_reg[k_reg];   mul_b = ct_reg;   end
            ST_C_A1:  begin mul_a = seg_reg[k_reg];  mul_b = cu_reg;   end
            default:  begin mul_a = '0;              mul_b = '0;       end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign qm_prod = rnep_pkg::qmul_fin(prod_reg);
    assign dot_val = rnep_pkg::sat32($signed(acc_reg));
    assign div_q   = rnep_pkg::div_fin(dv_num_reg, dv_neg_reg, dv_zero_reg);

    // Divider operand select
    always_comb
    begin
        dv_n   = '0;
        dv_d   = '0;
        dv_dir = 1'b0;
        case (state_reg)
            ST_E_UN:   begin dv_n = tnum_reg;       dv_d = den_reg;  end
            ST_E_TQ:   begin dv_n = unum_reg;       dv_d = den_reg;  end
            ST_E_PROJ: begin dv_n = ed_reg;         dv_d = len2_reg; end
            ST_D_DIV:  begin dv_n = dir_reg[k_reg]; dv_dir = 1'b1;   end
            default:   begin dv_n = '0;             dv_d = '0;       end
        endcase
    end

    assign dv_nmag = rnep_pkg::mag32(dv_n);
    assign dv_dmag = dv_dir ? sq_root_reg : rnep_pkg::mag32(dv_d);

    // One restoring divide step
    assign dv_remt = {dv_rem_reg, dv_num_reg[47]};
    assign dv_ge   = dv_remt >= {1'b0, dv_div_reg};

    // One restoring square-root step
    assign sq_remt  = {sq_rem_reg, sq_x_reg[63:62]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge    = sq_remt >= sq_trial;

    assign cnt_inc = {1'b0, cnt_edge_reg} + 1'b1;
    assign ux_nz   = (ux_reg[0] != '0) || (ux_reg[1] != '0) || (ux_reg[2] != '0);

    // Candidate beats the running best of this edge
    assign better = !s_have_reg || (sq_root_reg < s_d_reg) ||
                    ((sq_root_reg == s_d_reg) && (32'(ct_reg) < s_t_reg));

    // Sequencer, shared units and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            cons_ret_reg  <= ST_IDLE;
            vp_reg        <= VP_SS;
            k_reg         <= '0;
            pt_mode_reg   <= 1'b0;
            org_reg[0]    <= '0;
            org_reg[1]    <= '0;
            org_reg[2]    <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= rnep_pkg::QONE;
            radius_reg    <= rnep_pkg::RADIUS_W'(rnep_pkg::QONE);
            ux_reg[0]     <= '0;
            ux_reg[1]     <= '0;
            ux_reg[2]     <= '0;
            dir_ready_reg <= 1'b0;
            have_best_reg <= 1'b0;
            best_d_reg    <= '1;
            best_t_reg    <= '1;
            best_num_reg  <= '0;
            cnt_edge_reg  <= '0;
            s_have_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_p;

            // drop the result once taken
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_we)
            begin
                case (rnep_pkg::cfg_index_t'(cfg_addr))
                    rnep_pkg::REG_ORIGIN_X:    org_reg[0] <= cfg_wdata;
                    rnep_pkg::REG_ORIGIN_Y:    org_reg[1] <= cfg_wdata;
                    rnep_pkg::REG_ORIGIN_Z:    org_reg[2] <= cfg_wdata;
                    rnep_pkg::REG_DIRECTION_X: dir_reg[0] <= cfg_wdata;
                    rnep_pkg::REG_DIRECTION_Y: dir_reg[1] <= cfg_wdata;
                    rnep_pkg::REG_DIRECTION_Z: dir_reg[2] <= cfg_wdata;
                    rnep_pkg::REG_PICK_RADIUS: radius_reg <= cfg_wdata[rnep_pkg::RADIUS_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                // take one edge word
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            a_reg[i] <= coord_in[i];
                            b_reg[i] <= coord_in[3 + i];
                        end
                        cand_reg     <= s_tuser;
                        last_reg     <= s_tlast;
                        num_reg      <= cnt_edge_reg;
                        cnt_edge_reg <= (cnt_inc >= (CNT_W + 1)'(MAX_EDGES)) ?
                                        '0 : cnt_inc[CNT_W-1:0];
                        if (!dir_ready_reg)
                        begin
                            acc_reg   <= '0;
                            k_reg     <= '0;
                            vp_reg    <= VP_DD;
                            ret_reg   <= ST_D_LEN;
                            state_reg <= ST_DOT_M;
                        end
                        else
                        begin
                            state_reg <= ST_E_START;
                        end
                    end
                end

                // normalize the direction
                ST_D_LEN:
                begin
                    sq_x_reg    <= acc_reg;
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    cnt_reg     <= 6'd31;
                    ret_reg     <= ST_D_GOT;
                    state_reg   <= ST_SQ;
                end

                ST_D_GOT:
                begin
                    k_reg <= '0;
                    if (sq_root_reg == '0)
                    begin
                        ux_reg[0]     <= '0;
                        ux_reg[1]     <= '0;
                        ux_reg[2]     <= '0;
                        dir_ready_reg <= 1'b1;
                        state_reg     <= ST_E_START;
                    end
                    else
                    begin
                        state_reg <= ST_D_DIV;
                    end
                end

                ST_D_Q:
                begin
                    ux_reg[k_reg] <= div_q;
                    if (k_reg == 2'd2)
                    begin
                        dir_ready_reg <= 1'b1;
                        state_reg     <= ST_E_START;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_D_DIV;
                    end
                end

                // edge setup
                ST_E_START:
                begin
                    k_reg       <= '0;
                    s_have_reg  <= 1'b0;
                    pt_mode_reg <= 1'b0;
                    state_reg   <= (cand_reg && ux_nz) ? ST_E_SUB : ST_E_FIN;
                end

                ST_E_SUB:
                begin
                    seg_reg[k_reg] <= rnep_pkg::qsub(b_reg[k_reg], a_reg[k_reg]);
                    w0_reg[k_reg]  <= rnep_pkg::qsub(org_reg[k_reg], a_reg[k_reg]);
                    pa_reg[k_reg]  <= rnep_pkg::qsub(a_reg[k_reg], org_reg[k_reg]);
                    pb_reg[k_reg]  <= rnep_pkg::qsub(b_reg[k_reg], org_reg[k_reg]);
                    if (k_reg == 2'd2)
                    begin
                        acc_reg   <= '0;
                        k_reg     <= '0;
                        vp_reg    <= VP_SS;
                        ret_reg   <= ST_E_LEN2;
                        state_reg <= ST_DOT_M;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end

                ST_E_LEN2:
                begin
                    len2_reg  <= dot_val;
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    vp_reg    <= (dot_val == '0) ? VP_PR : VP_RS;
                    ret_reg   <= (dot_val == '0) ? ST_E_PT_T : ST_E_BD;
                    state_reg <= ST_DOT_M;
                end

                // point-like segment
                ST_E_PT_T:
                begin
                    if (dot_val <= 0)
                    begin
                        state_reg <= ST_E_FIN;
                    end
                    else
                    begin
                        ct_reg       <= dot_val;
                        cu_reg       <= '0;
                        pt_mode_reg  <= 1'b1;
                        cons_ret_reg <= ST_E_DONE;
                        state_reg    <= ST_C_CHK;
                    end
                end

                ST_E_BD:
                begin
                    bd_reg    <= dot_val;
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    vp_reg    <= VP_RW;
                    ret_reg   <= ST_E_DD;
                    state_reg <= ST_DOT_M;
                end

                ST_E_DD:
                begin
                    dd_reg    <= dot_val;
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    vp_reg    <= VP_SW;
                    ret_reg   <= ST_E_ED;
                    state_reg <= ST_DOT_M;
                end

                ST_E_ED:
                begin
                    ed_reg    <= dot_val;
                    state_reg <= ST_E_DEN;
                end

                ST_E_DEN:
                begin
                    den_reg   <= rnep_pkg::qsub(len2_reg, qm_prod);
                    state_reg <= ST_E_TN1;
                end

                ST_E_TN1:
                begin
                    tmp_reg   <= qm_prod;
                    state_reg <= ST_E_TN2;
                end

                ST_E_TN2:
                begin
                    tnum_reg  <= rnep_pkg::qsub(tmp_reg, qm_prod);
                    state_reg <= ST_E_UN;
                end

                // interior solution
                ST_E_UN:
                begin
                    unum_reg <= rnep_pkg::qsub(ed_reg, qm_prod);
                    if (den_reg != '0)
                    begin
                        dv_num_reg  <= {dv_nmag, 16'h0000};
                        dv_rem_reg  <= '0;
                        dv_div_reg  <= dv_dmag;
                        dv_neg_reg  <= dv_n[31] ^ dv_d[31];
                        dv_zero_reg <= (dv_dmag == '0);
                        cnt_reg     <= 6'd47;
                        ret_reg     <= ST_E_TQ;
                        state_reg   <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_E_PA;
                    end
                end

                ST_E_TQ:
                begin
                    ct_reg      <= div_q;
                    dv_num_reg  <= {dv_nmag, 16'h0000};
                    dv_rem_reg  <= '0;
                    dv_div_reg  <= dv_dmag;
                    dv_neg_reg  <= dv_n[31] ^ dv_d[31];
                    dv_zero_reg <= (dv_dmag == '0);
                    cnt_reg     <= 6'd47;
                    ret_reg     <= ST_E_UQ;
                    state_reg   <= ST_DIV;
                end

                ST_E_UQ:
                begin
                    cu_reg       <= div_q;
                    cons_ret_reg <= ST_E_PA;
                    state_reg    <= ST_C_CHK;
                end

                // start endpoint projected onto the ray
                ST_E_PA:
                begin
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    vp_reg    <= VP_PR;
                    ret_reg   <= ST_E_PAT;
                    state_reg <= ST_DOT_M;
                end

                ST_E_PAT:
                begin
                    if (dot_val > 0)
                    begin
                        ct_reg       <= dot_val;
                        cu_reg       <= '0;
                        cons_ret_reg <= ST_E_PB;
                        state_reg    <= ST_C_CHK;
                    end
                    else
                    begin
                        state_reg <= ST_E_PB;
                    end
                end

                // end endpoint projected onto the ray
                ST_E_PB:
                begin
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    vp_reg    <= VP_BR;
                    ret_reg   <= ST_E_PBT;
                    state_reg <= ST_DOT_M;
                end

                ST_E_PBT:
                begin
                    if (dot_val > 0)
                    begin
                        ct_reg       <= dot_val;
                        cu_reg       <= rnep_pkg::QONE;
                        cons_ret_reg <= ST_E_PROJ;
                        state_reg    <= ST_C_CHK;
                    end
                    else
                    begin
                        state_reg <= ST_E_PROJ;
                    end
                end

                // origin projected onto the segment
                ST_E_PROJ:
                begin
                    dv_num_reg  <= {dv_nmag, 16'h0000};
                    dv_rem_reg  <= '0;
                    dv_div_reg  <= dv_dmag;
                    dv_neg_reg  <= dv_n[31] ^ dv_d[31];
                    dv_zero_reg <= (dv_dmag == '0);
                    cnt_reg     <= 6'd47;
                    ret_reg     <= ST_E_PRU;
                    state_reg   <= ST_DIV;
                end

                ST_E_PRU:
                begin
                    if (div_q < 0)
                    begin
                        cu_reg <= '0;
                    end
                    else if (div_q > rnep_pkg::QONE)
                    begin
                        cu_reg <= rnep_pkg::QONE;
                    end
                    else
                    begin
                        cu_reg <= div_q;
                    end
                    ct_reg       <= '0;
                    cons_ret_reg <= ST_E_DONE;
                    state_reg    <= ST_C_CHK;
                end

                // keep the nearest edge within the radius
                ST_E_DONE:
                begin
                    if (s_have_reg && (s_d_reg <= {1'b0, radius_reg}))
                    begin
                        if (!have_best_reg || (s_d_reg < best_d_reg) ||
                            ((s_d_reg == best_d_reg) && (s_t_reg < best_t_reg)))
                        begin
                            have_best_reg <= 1'b1;
                            best_d_reg    <= s_d_reg;
                            best_t_reg    <= s_t_reg;
                            best_num_reg  <= num_reg;
                        end
                    end
                    state_reg <= ST_E_FIN;
                end

                // emit on the last edge and clear the query
                ST_E_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        m_tuser_reg   <= have_best_reg;
                        m_tdata_reg   <= have_best_reg ?
                            {1'b0, best_t_reg[rnep_pkg::PARAM_W-1:0],
                             rnep_pkg::EDGE_NUM_W'(best_num_reg)} : '0;
                        dir_ready_reg <= 1'b0;
                        have_best_reg <= 1'b0;
                        best_d_reg    <= '1;
                        best_t_reg    <= '1;
                        best_num_reg  <= '0;
                        cnt_edge_reg  <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end

                // try one (t, u) candidate
                ST_C_CHK:
                begin
                    k_reg <= '0;
                    if ((ct_reg < 0) || (cu_reg < 0) || (cu_reg > rnep_pkg::QONE))
                    begin
                        state_reg <= cons_ret_reg;
                    end
                    else
                    begin
                        state_reg <= ST_C_M1;
                    end
                end

                ST_C_M1:
                begin
                    state_reg <= ST_C_A1;
                end

                ST_C_A1:
                begin
                    if (pt_mode_reg)
                    begin
                        diff_reg[k_reg] <= rnep_pkg::qsub(pa_reg[k_reg], qm_prod);
                        if (k_reg == 2'd2)
                        begin
                            acc_reg   <= '0;
                            k_reg     <= '0;
                            vp_reg    <= VP_FF;
                            ret_reg   <= ST_C_LEN;
                            state_reg <= ST_DOT_M;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= ST_C_M1;
                        end
                    end
                    else
                    begin
                        tmp_reg   <= rnep_pkg::qadd(org_reg[k_reg], qm_prod);
                        state_reg <= ST_C_A2;
                    end
                end

                ST_C_A2:
                begin
                    diff_reg[k_reg] <= rnep_pkg::qsub(tmp_reg,
                        rnep_pkg::qadd(a_reg[k_reg], qm_prod));
                    if (k_reg == 2'd2)
                    begin
                        acc_reg   <= '0;
                        k_reg     <= '0;
                        vp_reg    <= VP_FF;
                        ret_reg   <= ST_C_LEN;
                        state_reg <= ST_DOT_M;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_C_M1;
                    end
                end

                ST_C_LEN:
                begin
                    sq_x_reg    <= acc_reg;
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    cnt_reg     <= 6'd31;
                    ret_reg     <= ST_C_CMP;
                    state_reg   <= ST_SQ;
                end

                ST_C_CMP:
                begin
                    if (better)
                    begin
                        s_have_reg <= 1'b1;
                        s_t_reg    <= 32'(ct_reg);
                        s_d_reg    <= sq_root_reg;
                    end
                    state_reg <= cons_ret_reg;
                end

                // dot product / sum of squares over three lanes
                ST_DOT_M:
                begin
                    state_reg <= ST_DOT_A;
                end

                ST_DOT_A:
                begin
                    acc_reg <= sq_mode ? (acc_reg + 64'(prod_reg)) :
                                         (acc_reg + 64'(qm_prod));
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_DOT_M;
                    end
                end

                // divider start for the direction lanes
                ST_D_DIV:
                begin
                    dv_num_reg  <= {dv_nmag, 16'h0000};
                    dv_rem_reg  <= '0;
                    dv_div_reg  <= dv_dmag;
                    dv_neg_reg  <= dv_n[31];
                    dv_zero_reg <= (dv_dmag == '0);
                    cnt_reg     <= 6'd47;
                    ret_reg     <= ST_D_Q;
                    state_reg   <= ST_DIV;
                end

                // one quotient bit per cycle
                ST_DIV:
                begin
                    dv_rem_reg <= dv_ge ? 32'(dv_remt - {1'b0, dv_div_reg}) : dv_remt[31:0];
                    dv_num_reg <= {dv_num_reg[46:0], dv_ge};
                    cnt_reg    <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ret_reg;
                    end
                end

                // one root bit per cycle
                ST_SQ:
                begin
                    sq_rem_reg  <= sq_ge ? 33'(sq_remt - sq_trial) : sq_remt[32:0];
                    sq_root_reg <= {sq_root_reg[30:0], sq_ge};
                    sq_x_reg    <= {sq_x_reg[61:0], 2'b00};
                    cnt_reg     <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ret_reg;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/core/rnep_checker.sv =====
// ----------------------------------------------------------------------------
// rnep_checker
// Port-level checks for the ray nearest-edge picker, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_nearest_edge_picker_assert.svh"

module rnep_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rnep_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    // block goes busy after taking an edge word
    `RNEP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // a not-found result carries a zero payload
    `RNEP_ASSERT_SAME(a_empty_result_zero, m_tvalid && !m_tuser, m_tdata == '0)

    // hold a stalled result word
    `RNEP_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind ray_nearest_edge_picker rnep_checker u_rnep_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/ray_nearest_edge_picker_test.sv =====
// ----------------------------------------------------------------------------
// ray_nearest_edge_picker_test
// Self-checking bench for the ray nearest-edge picker. Edge words are streamed
// in pick queries. A bit-exact Q16.16 model of the closest-approach search
// predicts each query result, and every result word is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_nearest_edge_picker_test;
    import rnep_pkg::*;

    localparam int  IN_W       = 192;
    localparam int  WATCH_MAX  = 20000;
    localparam int  HOLD_LEN   = 3000;
    localparam int  SETTLE     = 500;
    localparam longint ONE     = 65536;
    localparam longint SAT_HI  = 64'sh7fffffff;
    localparam longint SAT_LO  = -64'sh80000000;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int  NEAR       = 6 * 65536;

    typedef longint vec3_t [0:2];

    typedef struct {
        bit        found;
        bit [15:0] number;
        bit [30:0] param;
    } pick_t;

    logic                 clk;
    logic                 rst_n;
    logic [IN_W-1:0]      s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Register copy and query state of the prediction
    longint      ray_org [0:2];
    longint      ray_raw [0:2];
    longint      radius;
    longint      unit_dir [0:2];
    bit          dir_latched;
    longint      best_dist;
    longint      best_t;
    int unsigned best_num;
    bit          have_best;
    int unsigned edge_count;

    pick_t       pick_q [$];
    int          errors;
    bit          idle_on;
    bit          hold_req;
    int          gap_left;
    int          watch;

    ray_nearest_edge_picker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ---------------- Q16.16 arithmetic ----------------
    function automatic longint sat(input longint v);
        return v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return sat((a * b) >>> 16);
    endfunction

    function automatic longint qdiv(input longint n, input longint d);
        return d == 0 ? 0 : sat((n * ONE) / d);
    endfunction

    function automatic longint qdot(input vec3_t a, input vec3_t b);
        return sat(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
    endfunction

    function automatic longint qlen(input vec3_t v);
        longint unsigned x;
        longint unsigned res;
        longint unsigned bitv;
        x = 0;
        for (int i = 0; i < 3; i++)
            x += longint'(v[i] * v[i]);
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // Try one (t, u) pair of ray and segment parameters
    function automatic void try_pair(inout bit hv, inout longint st, inout longint sd,
                                     input vec3_t o, input vec3_t r, input vec3_t a,
                                     input vec3_t seg, input longint t, input longint u);
        vec3_t  diff;
        longint d;
        if (t < 0 || u < 0 || u > ONE)
            return;
        for (int i = 0; i < 3; i++)
            diff[i] = sat(sat(o[i] + qmul(r[i], t)) - sat(a[i] + qmul(seg[i], u)));
        d = qlen(diff);
        if (!hv || d < sd || (d == sd && t < st))
        begin
            hv = 1;
            st = t;
            sd = d;
        end
    endfunction

    // Closest approach of ray and segment; returns 0 when nothing qualifies
    function automatic bit closest_approach(input vec3_t a, input vec3_t b,
                                            input vec3_t o, input vec3_t r,
                                            output longint t_out, output longint d_out);
        vec3_t  seg, w0, pa, pb, diff;
        longint len2, bd, dd, ed, den, t, u, st, sd;
        bit     hv;
        t_out = 0;
        d_out = 0;
        for (int i = 0; i < 3; i++)
        begin
            seg[i] = sat(b[i] - a[i]);
            w0[i]  = sat(o[i] - a[i]);
            pa[i]  = sat(a[i] - o[i]);
            pb[i]  = sat(b[i] - o[i]);
        end
        len2 = qdot(seg, seg);
        // Point-like segment: distance of the start point to the ray
        if (len2 == 0)
        begin
            t = qdot(pa, r);
            if (t <= 0)
                return 0;
            for (int i = 0; i < 3; i++)
                diff[i] = sat(pa[i] - qmul(r[i], t));
            t_out = t;
            d_out = qlen(diff);
            return 1;
        end
        hv = 0;
        st = 0;
        sd = 0;
        bd = qdot(r, seg);
        dd = qdot(r, w0);
        ed = qdot(seg, w0);
        den = sat(len2 - qmul(bd, bd));
        if (den != 0)
        begin
            t = qdiv(sat(qmul(bd, ed) - qmul(len2, dd)), den);
            u = qdiv(sat(ed - qmul(bd, dd)), den);
            try_pair(hv, st, sd, o, r, a, seg, t, u);
        end
        t = qdot(pa, r);
        if (t > 0)
            try_pair(hv, st, sd, o, r, a, seg, t, 0);
        t = qdot(pb, r);
        if (t > 0)
            try_pair(hv, st, sd, o, r, a, seg, t, ONE);
        u = qdiv(ed, len2);
        if (u < 0)
            u = 0;
        if (u > ONE)
            u = ONE;
        try_pair(hv, st, sd, o, r, a, seg, 0, u);
        t_out = st;
        d_out = sd;
        return hv;
    endfunction

    function automatic void clear_query();
        dir_latched = 0;
        best_dist   = 64'hFFFFFFFF;
        best_t      = 64'hFFFFFFFF;
        best_num    = 0;
        have_best   = 0;
        edge_count  = 0;
    endfunction

    // Advance the search by one accepted edge word
    function automatic void pick_update(input logic [IN_W-1:0] data, input bit cand,
                                        input bit last);
        vec3_t       a, b, o, r, dv;
        longint      t, d, len;
        int unsigned number;
        pick_t       res;
        number = edge_count;
        if (!dir_latched)
        begin
            for (int i = 0; i < 3; i++)
                dv[i] = ray_raw[i];
            len = qlen(dv);
            for (int i = 0; i < 3; i++)
                unit_dir[i] = (len == 0) ? 0 : (dv[i] * ONE) / len;
            dir_latched = 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            r[i] = unit_dir[i];
            o[i] = ray_org[i];
            a[i] = longint'($signed(data[32*i +: 32]));
            b[i] = longint'($signed(data[32*(i+3) +: 32]));
        end
        if (cand && (r[0] != 0 || r[1] != 0 || r[2] != 0) &&
            closest_approach(a, b, o, r, t, d) && d <= radius)
        begin
            if (!have_best || d < best_dist || (d == best_dist && t < best_t))
            begin
                have_best = 1;
                best_dist = d;
                best_t    = t;
                best_num  = number;
            end
        end
        edge_count = (number + 1 >= MAX_EDGES_DEF) ? 0 : number + 1;
        if (last)
        begin
            res.found  = have_best;
            res.number = have_best ? best_num[15:0] : 16'd0;
            res.param  = have_best ? best_t[30:0] : 31'd0;
            pick_q.push_back(res);
            clear_query();
        end
    endfunction

    // ---------------- Stimulus helpers ----------------
    function automatic int pick_gap();
        return ($urandom_range(0, 19) < 16) ? $urandom_range(1, 3) : $urandom_range(20, 120);
    endfunction

    function automatic logic [31:0] near_coord();
        int v;
        v = $urandom_range(0, 2 * NEAR);
        return v - NEAR;
    endfunction

    function automatic logic [31:0] q(input int whole);
        return whole * 65536;
    endfunction

    task automatic send_edge(input logic [IN_W-1:0] data, input bit cand, input bit last);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = data;
        s_tuser  = cand;
        s_tlast  = last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pick_update(data, cand, last);
        @(negedge clk);
    endtask

    task automatic send_pts(input logic [31:0] ax, ay, az, bx, by, bz,
                            input bit cand, input bit last);
        send_edge({bz, by, bx, az, ay, az == az ? ax : ax}, cand, last);
    endtask

    // Wait for all results, then let the sequencer settle before a write
    task automatic drain();
        s_tvalid = 1'b0;
        while (pick_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        case (addr)
            REG_ORIGIN_X:    ray_org[0] = longint'($signed(value));
            REG_ORIGIN_Y:    ray_org[1] = longint'($signed(value));
            REG_ORIGIN_Z:    ray_org[2] = longint'($signed(value));
            REG_DIRECTION_X: ray_raw[0] = longint'($signed(value));
            REG_DIRECTION_Y: ray_raw[1] = longint'($signed(value));
            REG_DIRECTION_Z: ray_raw[2] = longint'($signed(value));
            REG_PICK_RADIUS: radius = longint'(value[30:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------- Result checking ----------------
    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pick_q.size() == 0)
                report_mismatch("unexpected result word", m_tuser, 0);
            else
            begin
                want = pick_q.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch("found", m_tuser, want.found);
                if (m_tdata[15:0] !== want.number)
                    report_mismatch("edge_number", m_tdata[15:0], want.number);
                if (m_tdata[46:16] !== want.param)
                    report_mismatch("ray_param", m_tdata[46:16], want.param);
            end
        end
    end

    // Count cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            watch <= 0;
        else if (watch + 1 >= WATCH_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            watch <= watch + 1;
    end

    // Result receiver: random stalls, plus a long hold on request
    initial
    begin
        m_tready = 1'b0;
        gap_left = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_tready = 1'b0;
            else if (hold_req)
            begin
                hold_req = 0;
                m_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end
            else if (gap_left > 0)
            begin
                m_tready = 1'b0;
                gap_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // ---------------- Tests ----------------
    task automatic test_directed();
        // Edge crossing the ray at z = 5
        send_pts(q(-1), 0, q(5), q(1), 0, q(5), 1, 1);
        // Same edge skipped: nothing found
        send_pts(q(-1), 0, q(5), q(1), 0, q(5), 0, 1);
        // Point-like edges in front of and behind the origin
        send_pts(32'h8000, 0, q(3), 32'h8000, 0, q(3), 1, 0);
        send_pts(0, 0, q(-2), 0, 0, q(-2), 1, 1);
        // Full tie: the earlier edge wins
        send_pts(q(-1), 32'h4000, q(2), q(1), 32'h4000, q(2), 1, 0);
        send_pts(q(-1), 32'h4000, q(2), q(1), 32'h4000, q(2), 1, 0);
        send_pts(q(-1), 32'h8000, q(1), q(1), 32'h8000, q(1), 1, 1);
        // Edge parallel to the ray
        send_pts(32'h8000, 0, q(1), 32'h8000, 0, q(4), 1, 1);
        // Saturating extremes
        send_pts(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0);
        send_pts(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0);
        send_pts(0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 1, 1);
        drain();
    endtask

    task automatic test_config_extremes();
        // Zero direction: nothing can be picked
        cfg_write(REG_DIRECTION_Z, 0);
        send_pts(q(-1), 0, q(5), q(1), 0, q(5), 1, 1);
        drain();
        // Largest direction, widest radius, extreme origin
        cfg_write(REG_DIRECTION_X, 32'h7fffffff);
        cfg_write(REG_DIRECTION_Y, 32'h7fffffff);
        cfg_write(REG_DIRECTION_Z, 32'h80000000);
        cfg_write(REG_PICK_RADIUS, 32'h7fffffff);
        cfg_write(REG_ORIGIN_X, 32'h80000000);
        cfg_write(REG_ORIGIN_Y, 32'h7fffffff);
        cfg_write(REG_ORIGIN_Z, 32'h80000000);
        cfg_write(REG_UNUSED, 32'hffffffff);
        send_pts(0, 0, 0, q(3), q(3), q(-3), 1, 0);
        send_pts(32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h80000000, 32'h7fffffff, 32'h80000000, 1, 1);
        drain();
        // Zero radius: only exact hits count
        cfg_write(REG_ORIGIN_X, 0);
        cfg_write(REG_ORIGIN_Y, 0);
        cfg_write(REG_ORIGIN_Z, 0);
        cfg_write(REG_DIRECTION_X, 0);
        cfg_write(REG_DIRECTION_Y, 0);
        cfg_write(REG_DIRECTION_Z, q(2));
        cfg_write(REG_PICK_RADIUS, 0);
        send_pts(q(-1), 0, q(5), q(1), 0, q(5), 1, 0);
        send_pts(q(-1), q(1), q(2), q(1), q(1), q(2), 1, 1);
        drain();
        cfg_write(REG_PICK_RADIUS, q(1));
    endtask

    // Query longer than the edge counter range
    task automatic test_long_query();
        idle_on = 0;
        for (int n = 0; n < MAX_EDGES_DEF + 12; n++)
        begin
            if (n == 10)
                send_pts(q(-1), 32'h8000, q(4), q(1), 32'h8000, q(4), 1, 0);
            else if (n == MAX_EDGES_DEF + 5)
                send_pts(q(-1), 32'h2000, q(6), q(1), 32'h2000, q(6), 1, 0);
            else
                send_pts(near_coord(), near_coord(), near_coord(),
                         near_coord(), near_coord(), near_coord(), 0,
                         n == MAX_EDGES_DEF + 11);
        end
        drain();
        idle_on = 1;
    endtask

    // Receiver holds off while single-edge queries keep coming
    task automatic test_backpressure();
        hold_req = 1;
        for (int n = 0; n < 8; n++)
            send_pts(near_coord(), near_coord(), q(3), near_coord(), near_coord(), q(4), 1, 1);
        drain();
    endtask

    task automatic random_config();
        cfg_write(REG_ORIGIN_X, ($urandom_range(0, 9) == 0) ? $urandom() : near_coord() >>> 2);
        cfg_write(REG_ORIGIN_Y, ($urandom_range(0, 9) == 0) ? $urandom() : near_coord() >>> 2);
        cfg_write(REG_ORIGIN_Z, ($urandom_range(0, 9) == 0) ? $urandom() : near_coord() >>> 2);
        cfg_write(REG_DIRECTION_X, ($urandom_range(0, 9) == 0) ? $urandom() : near_coord());
        cfg_write(REG_DIRECTION_Y, ($urandom_range(0, 9) == 0) ? $urandom() : near_coord());
        cfg_write(REG_DIRECTION_Z, ($urandom_range(0, 9) == 0) ? $urandom() : near_coord());
        cfg_write(REG_PICK_RADIUS, ($urandom_range(0, 9) == 0) ? $urandom() :
                                   $urandom_range(0, 4 * 65536));
    endtask

    task automatic test_random();
        int          sent;
        int          len;
        logic [31:0] c [0:5];
        sent = 0;
        while (sent < 900)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
                idle_on = ($urandom_range(0, 4) != 0);
                random_config();
            end
            len = $urandom_range(1, 8);
            for (int n = 0; n < len; n++)
            begin
                for (int k = 0; k < 6; k++)
                    c[k] = ($urandom_range(0, 9) == 0) ? $urandom() : near_coord();
                // Point-like edge now and then
                if ($urandom_range(0, 9) == 0)
                    for (int k = 0; k < 3; k++)
                        c[k + 3] = c[k];
                send_edge({c[5], c[4], c[3], c[2], c[1], c[0]},
                          $urandom_range(0, 7) != 0, n == len - 1);
                sent++;
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        s_tvalid  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_ORIGIN_X;
        cfg_wdata = '0;
        errors    = 0;
        idle_on   = 1;
        hold_req  = 0;
        watch     = 0;
        for (int i = 0; i < 3; i++)
        begin
            ray_org[i]  = 0;
            ray_raw[i]  = 0;
            unit_dir[i] = 0;
        end
        ray_raw[2] = ONE;
        radius     = ONE;
        clear_query();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_long_query();
        test_random();

        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
